// ----- src/tcrq_pkg.sv -----
// tcrq_pkg: shared sizes, word types and codes of the two-class request queue.
// No dependencies; used by every module in src.
`default_nettype none

package tcrq_pkg;

    localparam int DEPTH      = 64;
    localparam int ITEM_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int COUNT_W    = 7;
    localparam int POS_W      = 6;
    localparam int CAP_W      = 7;
    localparam int LIMIT_W    = 8;
    localparam int RUN_W      = 8;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    // register index, taken from paddr[2]
    localparam logic REG_CAPACITY     = 1'b0;
    localparam logic REG_STARVE_LIMIT = 1'b1;

    localparam logic [CAP_W-1:0]   CAPACITY_RESET = CAP_W'(50);
    localparam logic [LIMIT_W-1:0] STARVE_RESET   = LIMIT_W'(10);

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_READ_AT = 2'd2,
        OP_NOP     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_op                     op;
        logic                    is_simple;
        logic [ITEM_WIDTH-1:0]   payload;
        logic                    queue_select;
        logic [POS_W-1:0]        position;
    } t_in_word;

    typedef struct packed {
        logic [ITEM_WIDTH-1:0]   item;
        t_status                 status;
        logic                    from_priority;
        logic [COUNT_W-1:0]      priority_count;
        logic [COUNT_W-1:0]      normal_count;
    } t_out_word;

    // store access issued by the control stage
    typedef struct packed {
        logic                    wr_en;
        logic                    wr_pri;
        logic [ADDR_W-1:0]       wr_addr;
        logic [ITEM_WIDTH-1:0]   wr_data;
        logic                    rd_en;
        logic                    rd_pri;
        logic [ADDR_W-1:0]       rd_addr;
    } t_mem_req;

    // result fields known before the store data returns
    typedef struct packed {
        t_status                 status;
        logic                    from_priority;
        logic [COUNT_W-1:0]      priority_count;
        logic [COUNT_W-1:0]      normal_count;
        logic                    use_data;
        logic                    rd_pri;
    } t_res_info;

endpackage

`default_nettype wire

// ----- src/two_class_request_queue_unit.sv -----
// two_class_request_queue_unit: top level of the two-class request queue.
// Depends on tcrq_pkg, tcrq_ctrl and tcrq_store.
//
//   channel  direction  handshake                  word
//   in       input      i_in_valid / o_in_ready    i_in_word  (t_in_word)
//   out      output     o_out_valid / i_out_ready  o_out_word (t_out_word)
//   config   input      APB psel/penable/pwrite    capacity @0x0, starve_limit @0x4
//
// One word per cycle sustained while the receiver keeps out ready high. The
// input register feeds the control decision and the store access, and the
// store's registered read data plus the result fields form the output register.
// Stalls: a waiting result holds the output stage; the input register still
// takes one more word, so in ready drops only when both stages are full.
// Reset (synchronous, active low) empties both queues and restores
// capacity 50 and starve_limit 10; store contents are not cleared.
`default_nettype none

module two_class_request_queue_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire tcrq_pkg::t_in_word                i_in_word,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output tcrq_pkg::t_out_word                    o_out_word,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [tcrq_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [tcrq_pkg::PDATA_W-1:0]      pwdata,
    output logic [tcrq_pkg::PDATA_W-1:0]           prdata,
    output logic                                   pready
);
    import tcrq_pkg::*;

    // configuration registers
    logic [CAP_W-1:0]   r_capacity;
    logic [LIMIT_W-1:0] r_starve_limit;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity     <= CAPACITY_RESET;
            r_starve_limit <= STARVE_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_CAPACITY) begin
                r_capacity <= pwdata[CAP_W-1:0];
            end else begin
                r_starve_limit <= pwdata[LIMIT_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_STARVE_LIMIT) begin
            prdata = PDATA_W'(r_starve_limit);
        end else begin
            prdata = PDATA_W'(r_capacity);
        end
    end

    // pipeline control: A = input register, B = output register
    logic      r_a_valid;
    t_in_word  r_a_word;
    logic      r_b_valid;
    t_res_info r_b_info;
    logic      b_load;
    logic      a_fire;

    assign b_load     = !r_b_valid || i_out_ready;
    assign a_fire     = r_a_valid && b_load;
    assign o_in_ready = !r_a_valid || a_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_a_word <= i_in_word;
        end
    end

    // decision, pointer and count update
    t_mem_req  mem_req;
    t_res_info res_info;

    tcrq_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (a_fire),
        .i_word         (r_a_word),
        .i_capacity     (r_capacity),
        .i_starve_limit (r_starve_limit),
        .o_mem_req      (mem_req),
        .o_res_info     (res_info)
    );

    // stores: read data lands with the output register
    logic [ITEM_WIDTH-1:0] pri_rd_data;
    logic [ITEM_WIDTH-1:0] norm_rd_data;

    tcrq_store u_pri_store (
        .i_clk     (i_clk),
        .i_wr_en   (a_fire && mem_req.wr_en && mem_req.wr_pri),
        .i_wr_addr (mem_req.wr_addr),
        .i_wr_data (mem_req.wr_data),
        .i_rd_en   (a_fire && mem_req.rd_en && mem_req.rd_pri),
        .i_rd_addr (mem_req.rd_addr),
        .o_rd_data (pri_rd_data)
    );

    tcrq_store u_norm_store (
        .i_clk     (i_clk),
        .i_wr_en   (a_fire && mem_req.wr_en && !mem_req.wr_pri),
        .i_wr_addr (mem_req.wr_addr),
        .i_wr_data (mem_req.wr_data),
        .i_rd_en   (a_fire && mem_req.rd_en && !mem_req.rd_pri),
        .i_rd_addr (mem_req.rd_addr),
        .o_rd_data (norm_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_load) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_b_info <= res_info;
        end
    end

    // result word: item is zero unless a read or dequeue succeeded
    always_comb begin
        o_out_valid               = r_b_valid;
        o_out_word.status         = r_b_info.status;
        o_out_word.from_priority  = r_b_info.from_priority;
        o_out_word.priority_count = r_b_info.priority_count;
        o_out_word.normal_count   = r_b_info.normal_count;
        if (!r_b_info.use_data) begin
            o_out_word.item = '0;
        end else if (r_b_info.rd_pri) begin
            o_out_word.item = pri_rd_data;
        end else begin
            o_out_word.item = norm_rd_data;
        end
    end

    // checks
    a_item_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status != ST_OK) |-> o_out_word.item == '0)
        else $error("item not zero on failed operation");

    a_from_pri_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.from_priority |-> o_out_word.status == ST_OK)
        else $error("priority serve flagged without ok status");

    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.priority_count <= COUNT_W'(DEPTH))
                     && (o_out_word.normal_count <= COUNT_W'(DEPTH)))
        else $error("queue count beyond store depth");

    a_stage_a_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !a_fire |=> r_a_valid && $stable(r_a_word))
        else $error("input register lost a stalled word");

endmodule

`default_nettype wire

// ----- src/tcrq_store.sv -----
// tcrq_store: one item store, single write port and one registered read port.
// Depends on tcrq_pkg for sizes.
`default_nettype none

module tcrq_store (
    input  wire logic                          i_clk,
    input  wire logic                          i_wr_en,
    input  wire logic [tcrq_pkg::ADDR_W-1:0]   i_wr_addr,
    input  wire logic [tcrq_pkg::ITEM_WIDTH-1:0] i_wr_data,
    input  wire logic                          i_rd_en,
    input  wire logic [tcrq_pkg::ADDR_W-1:0]   i_rd_addr,
    output logic [tcrq_pkg::ITEM_WIDTH-1:0]    o_rd_data
);
    import tcrq_pkg::*;

    logic [ITEM_WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds while the read enable is low
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- src/tcrq_ctrl.sv -----
// tcrq_ctrl: queue pointers, counts and starvation run; decides each operation.
// Depends on tcrq_pkg for types and codes.
`default_nettype none

module tcrq_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_fire,
    input  wire tcrq_pkg::t_in_word            i_word,
    input  wire logic [tcrq_pkg::CAP_W-1:0]    i_capacity,
    input  wire logic [tcrq_pkg::LIMIT_W-1:0]  i_starve_limit,
    output tcrq_pkg::t_mem_req                 o_mem_req,
    output tcrq_pkg::t_res_info                o_res_info
);
    import tcrq_pkg::*;

    logic [ADDR_W-1:0]  r_pri_head, r_pri_tail, r_norm_head, r_norm_tail;
    logic [ADDR_W-1:0]  n_pri_head, n_pri_tail, n_norm_head, n_norm_tail;
    logic [COUNT_W-1:0] r_pri_cnt, r_norm_cnt, n_pri_cnt, n_norm_cnt;
    logic [RUN_W-1:0]   r_run, n_run;

    logic [COUNT_W:0]   total;
    logic [CAP_W-1:0]   limit;
    logic [COUNT_W-1:0] own_cnt;
    logic               is_full;
    logic               serve_pri;
    logic [COUNT_W-1:0] sel_cnt;
    logic [ADDR_W-1:0]  sel_head;
    logic [COUNT_W-1:0] pos_ext;
    logic [COUNT_W-1:0] offset;

    always_comb begin
        total    = {1'b0, r_pri_cnt} + {1'b0, r_norm_cnt};
        limit    = (i_capacity == '0) ? '0 : i_capacity - CAP_W'(1);
        own_cnt  = i_word.is_simple ? r_pri_cnt : r_norm_cnt;
        is_full  = (total >= (COUNT_W+1)'(limit)) || (own_cnt >= COUNT_W'(DEPTH));
        // priority wins unless normal waits and the run is past the limit
        serve_pri = (r_pri_cnt != '0)
                  && !((r_norm_cnt != '0) && (r_run > i_starve_limit));
        sel_cnt  = i_word.queue_select ? r_pri_cnt : r_norm_cnt;
        sel_head = i_word.queue_select ? r_pri_head : r_norm_head;
        pos_ext  = COUNT_W'(i_word.position);
        offset   = (pos_ext >= sel_cnt) ? sel_cnt - COUNT_W'(1) : pos_ext;
    end

    always_comb begin
        n_pri_head  = r_pri_head;
        n_pri_tail  = r_pri_tail;
        n_norm_head = r_norm_head;
        n_norm_tail = r_norm_tail;
        n_pri_cnt   = r_pri_cnt;
        n_norm_cnt  = r_norm_cnt;
        n_run       = r_run;

        o_mem_req.wr_en   = 1'b0;
        o_mem_req.wr_pri  = i_word.is_simple;
        o_mem_req.wr_addr = i_word.is_simple ? r_pri_tail : r_norm_tail;
        o_mem_req.wr_data = i_word.payload;
        o_mem_req.rd_en   = 1'b0;
        o_mem_req.rd_pri  = 1'b0;
        o_mem_req.rd_addr = r_norm_head;

        o_res_info.status        = ST_OK;
        o_res_info.from_priority = 1'b0;
        o_res_info.use_data      = 1'b0;

        case (i_word.op)
            OP_ENQUEUE: begin
                if (is_full) begin
                    o_res_info.status = ST_FULL;
                end else begin
                    o_mem_req.wr_en = 1'b1;
                    if (i_word.is_simple) begin
                        n_pri_tail = r_pri_tail + ADDR_W'(1);
                        n_pri_cnt  = r_pri_cnt + COUNT_W'(1);
                    end else begin
                        n_norm_tail = r_norm_tail + ADDR_W'(1);
                        n_norm_cnt  = r_norm_cnt + COUNT_W'(1);
                    end
                end
            end
            OP_DEQUEUE: begin
                if ((r_pri_cnt == '0) && (r_norm_cnt == '0)) begin
                    o_res_info.status = ST_EMPTY;
                end else if (serve_pri) begin
                    o_mem_req.rd_en          = 1'b1;
                    o_mem_req.rd_pri         = 1'b1;
                    o_mem_req.rd_addr        = r_pri_head;
                    o_res_info.use_data      = 1'b1;
                    o_res_info.from_priority = 1'b1;
                    n_pri_head = r_pri_head + ADDR_W'(1);
                    n_pri_cnt  = r_pri_cnt - COUNT_W'(1);
                    if (r_run != '1) begin
                        n_run = r_run + RUN_W'(1);
                    end
                end else begin
                    o_mem_req.rd_en     = 1'b1;
                    o_mem_req.rd_addr   = r_norm_head;
                    o_res_info.use_data = 1'b1;
                    n_norm_head = r_norm_head + ADDR_W'(1);
                    n_norm_cnt  = r_norm_cnt - COUNT_W'(1);
                    n_run       = '0;
                end
            end
            OP_READ_AT: begin
                if (sel_cnt == '0) begin
                    o_res_info.status = ST_EMPTY;
                end else begin
                    o_mem_req.rd_en     = 1'b1;
                    o_mem_req.rd_pri    = i_word.queue_select;
                    o_mem_req.rd_addr   = sel_head + offset[ADDR_W-1:0];
                    o_res_info.use_data = 1'b1;
                end
            end
            default: begin
                // no operation: status ok, counts unchanged
            end
        endcase

        o_res_info.rd_pri         = o_mem_req.rd_pri;
        o_res_info.priority_count = n_pri_cnt;
        o_res_info.normal_count   = n_norm_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pri_head  <= '0;
            r_pri_tail  <= '0;
            r_norm_head <= '0;
            r_norm_tail <= '0;
            r_pri_cnt   <= '0;
            r_norm_cnt  <= '0;
            r_run       <= '0;
        end else if (i_fire) begin
            r_pri_head  <= n_pri_head;
            r_pri_tail  <= n_pri_tail;
            r_norm_head <= n_norm_head;
            r_norm_tail <= n_norm_tail;
            r_pri_cnt   <= n_pri_cnt;
            r_norm_cnt  <= n_norm_cnt;
            r_run       <= n_run;
        end
    end

endmodule

`default_nettype wire

// ----- tb/sv/two_class_request_queue_unit_tb.sv -----
// Self-checking testbench for two_class_request_queue_unit: directed and random
// enqueue/dequeue/read-at traffic, APB register changes between phases.
// Depends on tcrq_pkg and the RTL in src; reads no files.
`default_nettype none

module two_class_request_queue_unit_tb;
    import tcrq_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam logic [PADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};
    localparam logic [PADDR_W-1:0] LIMIT_ADDR    = {REG_STARVE_LIMIT, 2'b00};

    // ---------------------------------------------------------------------
    // Clock, reset and DUT hookup. Every input starts at a known value.
    // ---------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic           in_valid = 1'b0;
    logic           in_ready;
    t_in_word       in_word = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    t_out_word      out_word;
    logic           psel = 1'b0;
    logic           penable = 1'b0;
    logic           pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic           pready;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    two_class_request_queue_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // ---------------------------------------------------------------------
    // Shadow of the queue state. Updated in acceptance order, so the
    // outcome of each request word is known the moment the DUT takes it.
    // ---------------------------------------------------------------------
    logic [ITEM_WIDTH-1:0] pri_mem [DEPTH];
    logic [ITEM_WIDTH-1:0] nrm_mem [DEPTH];
    logic [ADDR_W-1:0]     pri_head = '0, pri_tail = '0;
    logic [ADDR_W-1:0]     nrm_head = '0, nrm_tail = '0;
    int                    pri_cnt = 0, nrm_cnt = 0;
    int                    pri_run = 0;
    int                    cap_reg = int'(CAPACITY_RESET);
    int                    limit_reg = int'(STARVE_RESET);

    t_in_word  request_backlog [$];   // words waiting for the driver
    t_out_word pending_outcomes [$];  // expected result words, oldest first
    t_out_word want_word;
    int        fails = 0;
    int        quiet_cycles = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;

    function automatic t_out_word queue_op_outcome(t_in_word w);
        t_out_word r;
        int lim, own, cnt, off;
        logic [ADDR_W-1:0] idx;
        r = '0;
        r.status = ST_OK;
        case (w.op)
            OP_ENQUEUE: begin
                lim = (cap_reg > 0) ? cap_reg - 1 : 0;
                own = w.is_simple ? pri_cnt : nrm_cnt;
                // shared capacity first, then the per-class storage depth
                if (pri_cnt + nrm_cnt >= lim || own >= DEPTH) begin
                    r.status = ST_FULL;
                end else if (w.is_simple) begin
                    pri_mem[pri_tail] = w.payload;
                    pri_tail = pri_tail + ADDR_W'(1);
                    pri_cnt++;
                end else begin
                    nrm_mem[nrm_tail] = w.payload;
                    nrm_tail = nrm_tail + ADDR_W'(1);
                    nrm_cnt++;
                end
            end
            OP_DEQUEUE: begin
                if (pri_cnt == 0 && nrm_cnt == 0) begin
                    r.status = ST_EMPTY;
                end else if (pri_cnt != 0 && !(nrm_cnt != 0 && pri_run > limit_reg)) begin
                    r.item = pri_mem[pri_head];
                    r.from_priority = 1'b1;
                    pri_head = pri_head + ADDR_W'(1);
                    pri_cnt--;
                    if (pri_run < 255) pri_run++;   // counts even with normal empty
                end else begin
                    r.item = nrm_mem[nrm_head];
                    nrm_head = nrm_head + ADDR_W'(1);
                    nrm_cnt--;
                    pri_run = 0;
                end
            end
            OP_READ_AT: begin
                cnt = w.queue_select ? pri_cnt : nrm_cnt;
                if (cnt == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // positions at or past the count clamp to the tail entry
                    off = (int'(w.position) >= cnt) ? cnt - 1 : int'(w.position);
                    idx = (w.queue_select ? pri_head : nrm_head) + ADDR_W'(off);
                    r.item = w.queue_select ? pri_mem[idx] : nrm_mem[idx];
                end
            end
            default: ;  // no-op: ok, zero item, counts only
        endcase
        r.priority_count = COUNT_W'(pri_cnt);
        r.normal_count   = COUNT_W'(nrm_cnt);
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Driver: predicts on acceptance, then offers the next word unless an
    // idle cycle is drawn. Valid stays up with a steady word until taken.
    // ---------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready)
                pending_outcomes.push_back(queue_op_outcome(in_word));
            if (!in_valid || in_ready) begin
                if (request_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_word  <= request_backlog.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: field-by-field compare against the oldest expectation; also
    // draws the receiver stall for the next cycle.
    // ---------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (out_valid && out_ready) begin
                if (pending_outcomes.size() == 0) begin
                    $error("result word %h with nothing expected", out_word);
                    fails++;
                end else begin
                    want_word = pending_outcomes.pop_front();
                    if (out_word.item !== want_word.item) begin
                        $error("item: expected %h, actual %h", want_word.item, out_word.item);
                        fails++;
                    end
                    if (out_word.status !== want_word.status) begin
                        $error("status: expected %0d, actual %0d",
                               want_word.status, out_word.status);
                        fails++;
                    end
                    if (out_word.from_priority !== want_word.from_priority) begin
                        $error("from_priority: expected %0d, actual %0d",
                               want_word.from_priority, out_word.from_priority);
                        fails++;
                    end
                    if (out_word.priority_count !== want_word.priority_count) begin
                        $error("priority_count: expected %0d, actual %0d",
                               want_word.priority_count, out_word.priority_count);
                        fails++;
                    end
                    if (out_word.normal_count !== want_word.normal_count) begin
                        $error("normal_count: expected %0d, actual %0d",
                               want_word.normal_count, out_word.normal_count);
                        fails++;
                    end
                end
            end
        end
    end

    // Watchdog: any handshake or APB activity counts as progress.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    function automatic t_in_word req(t_op op, logic simple, logic [ITEM_WIDTH-1:0] data,
                                     logic sel, logic [POS_W-1:0] pos);
        t_in_word w;
        w.op = op;
        w.is_simple = simple;
        w.payload = data;
        w.queue_select = sel;
        w.position = pos;
        return w;
    endfunction

    // Sampled on the falling edge so queue updates at the rising edge have settled.
    task automatic drain();
        do @(negedge clk);
        while (request_backlog.size() != 0 || in_valid || pending_outcomes.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);             // register takes the value on this edge
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Only called with the queue idle; shadow copies follow the writes.
    task automatic configure(int cap, int lim);
        apb_write(CAPACITY_ADDR, PDATA_W'(cap));
        apb_write(LIMIT_ADDR, PDATA_W'(lim));
        cap_reg = cap;
        limit_reg = lim;
    endtask

    // Random mix that swings between filling and draining tides so the
    // queue reaches both full and empty under every setting.
    task automatic push_random(int n);
        int tide_left, enq_pct, pick;
        t_in_word w;
        tide_left = 0;
        enq_pct = 25;
        for (int k = 0; k < n; k++) begin
            if (tide_left == 0) begin
                enq_pct = (enq_pct > 50) ? 25 : 75;
                tide_left = $urandom_range(15, 90);
            end
            tide_left--;
            pick = $urandom_range(0, 99);
            if (pick < enq_pct) begin
                w.op = OP_ENQUEUE;
            end else begin
                pick = $urandom_range(0, 19);
                w.op = (pick < 12) ? OP_DEQUEUE : (pick < 19) ? OP_READ_AT : OP_NOP;
            end
            w.is_simple = 1'($urandom_range(0, 1));
            w.payload = $urandom();
            w.queue_select = 1'($urandom_range(0, 1));
            w.position = $urandom_range(0, 1) ? POS_W'($urandom_range(0, 63))
                                               : POS_W'($urandom_range(0, 7));
            request_backlog.push_back(w);
        end
    endtask

    // ---------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // sender idles rarely, receiver stalls most cycles
        send_idle_pct = 6;
        recv_stall_pct = 87;

        // reset settings: empty cases, field extremes, clamped reads, no-op
        request_backlog.push_back(req(OP_DEQUEUE, 1'b0, '0, 1'b0, '0));
        request_backlog.push_back(req(OP_READ_AT, 1'b0, '0, 1'b0, '0));
        request_backlog.push_back(req(OP_READ_AT, 1'b0, '0, 1'b1, '1));
        request_backlog.push_back(req(OP_NOP, 1'b1, '1, 1'b1, '1));
        request_backlog.push_back(req(OP_ENQUEUE, 1'b1, '0, 1'b0, '0));
        request_backlog.push_back(req(OP_ENQUEUE, 1'b1, '1, 1'b0, '0));
        request_backlog.push_back(req(OP_ENQUEUE, 1'b0, 32'hA5A5_A5A5, 1'b0, '0));
        request_backlog.push_back(req(OP_ENQUEUE, 1'b0, 32'h5A5A_5A5A, 1'b0, '0));
        request_backlog.push_back(req(OP_READ_AT, 1'b0, '0, 1'b1, 6'd0));
        request_backlog.push_back(req(OP_READ_AT, 1'b0, '0, 1'b1, 6'd1));
        request_backlog.push_back(req(OP_READ_AT, 1'b0, '0, 1'b1, 6'd2));
        request_backlog.push_back(req(OP_READ_AT, 1'b0, '0, 1'b0, '1));
        request_backlog.push_back(req(OP_NOP, 1'b0, '0, 1'b0, '0));
        repeat (4) request_backlog.push_back(req(OP_DEQUEUE, 1'b0, '0, 1'b0, '0));
        request_backlog.push_back(req(OP_DEQUEUE, 1'b1, '1, 1'b1, '1));
        drain();

        // capacity zero and one: every enqueue refused, counts untouched
        configure(0, 10);
        request_backlog.push_back(req(OP_ENQUEUE, 1'b1, 32'h1111_1111, 1'b0, '0));
        request_backlog.push_back(req(OP_ENQUEUE, 1'b0, 32'h2222_2222, 1'b0, '0));
        drain();
        configure(1, 10);
        request_backlog.push_back(req(OP_ENQUEUE, 1'b1, 32'h3333_3333, 1'b0, '0));
        drain();

        // smallest useful capacity: one entry, second refused
        configure(2, 10);
        request_backlog.push_back(req(OP_ENQUEUE, 1'b0, 32'h4444_4444, 1'b0, '0));
        request_backlog.push_back(req(OP_ENQUEUE, 1'b1, 32'h5555_5555, 1'b0, '0));
        request_backlog.push_back(req(OP_READ_AT, 1'b0, '0, 1'b0, 6'd5));
        request_backlog.push_back(req(OP_DEQUEUE, 1'b0, '0, 1'b0, '0));
        drain();

        // capacity above storage: priority class fills its 64 slots, then
        // gets refused while normal still takes words; limit 0 alternates
        configure(127, 0);
        repeat (66) request_backlog.push_back(req(OP_ENQUEUE, 1'b1, $urandom(), 1'b0, '0));
        repeat (3) request_backlog.push_back(req(OP_ENQUEUE, 1'b0, $urandom(), 1'b0, '0));
        request_backlog.push_back(req(OP_READ_AT, 1'b0, '0, 1'b1, '1));
        request_backlog.push_back(req(OP_READ_AT, 1'b0, '0, 1'b0, '1));
        repeat (6) request_backlog.push_back(req(OP_DEQUEUE, 1'b0, '0, 1'b0, '0));
        push_random(200);
        drain();

        // receiver mostly ready, sender idles most cycles
        send_idle_pct = 87;
        recv_stall_pct = 6;
        configure(64, 3);
        push_random(250);
        drain();

        // run counter saturation: long priority-only serve streak at the
        // top limit, then limit 254 must hand the next dequeue to normal
        configure(64, 255);
        repeat (262) begin
            request_backlog.push_back(req(OP_ENQUEUE, 1'b1, $urandom(), 1'b0, '0));
            request_backlog.push_back(req(OP_DEQUEUE, 1'b0, '0, 1'b0, '0));
        end
        drain();
        configure(64, 254);
        request_backlog.push_back(req(OP_ENQUEUE, 1'b0, $urandom(), 1'b0, '0));
        request_backlog.push_back(req(OP_ENQUEUE, 1'b1, $urandom(), 1'b0, '0));
        repeat (3) request_backlog.push_back(req(OP_DEQUEUE, 1'b0, '0, 1'b0, '0));
        drain();

        // full rate on both sides
        send_idle_pct = 0;
        recv_stall_pct = 0;
        configure(10, 1);
        push_random(150);
        drain();
        configure(64, 7);
        push_random(120);
        drain();

        repeat (8) @(posedge clk);
        if (fails == 0 && pending_outcomes.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
src/tcrq_pkg.sv
src/tcrq_store.sv
src/tcrq_ctrl.sv
src/two_class_request_queue_unit.sv
tb/sv/two_class_request_queue_unit_tb.sv
